// ----- design/rv64_instruction_decoder_core_assert.svh -----
// Assertion macros shared by the instruction decoder modules.
// No dependencies; include inside a module body after the package import.
`ifndef RV64_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define RV64_INSTRUCTION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RVD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvd assertion failed");

`endif

// ----- design/rvd_pkg.sv -----
// Shared constants, opcode classes, mnemonic codes and stage structs
// for the RV64I instruction decoder. No dependencies.
package rvd_pkg;

  localparam int ADDR_WIDTH = 64;

  // Major opcodes, bits 6..0
  localparam logic [6:0] OPC_MASK   = 7'h7f;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

  // funct values used by the decode
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef enum logic [3:0] {
    CLS_OP_IMM,
    CLS_OP,
    CLS_AUIPC,
    CLS_LUI,
    CLS_JAL,
    CLS_JALR,
    CLS_BRANCH,
    CLS_LOAD,
    CLS_STORE,
    CLS_SYSTEM,
    CLS_NONE
  } cls_t;

  // Mnemonic codes, dense in decode order
  localparam logic [5:0] OP_ADDI         = 6'd0;
  localparam logic [5:0] OP_ORI          = 6'd1;
  localparam logic [5:0] OP_ANDI         = 6'd2;
  localparam logic [5:0] OP_XORI         = 6'd3;
  localparam logic [5:0] OP_SLLI         = 6'd4;
  localparam logic [5:0] OP_SRAI         = 6'd5;
  localparam logic [5:0] OP_SRLI         = 6'd6;
  localparam logic [5:0] OP_OTHER_IMM    = 6'd7;
  localparam logic [5:0] OP_ADD          = 6'd8;
  localparam logic [5:0] OP_SUB          = 6'd9;
  localparam logic [5:0] OP_AND          = 6'd10;
  localparam logic [5:0] OP_OR           = 6'd11;
  localparam logic [5:0] OP_XOR          = 6'd12;
  localparam logic [5:0] OP_OTHER_OP     = 6'd13;
  localparam logic [5:0] OP_AUIPC        = 6'd14;
  localparam logic [5:0] OP_LUI          = 6'd15;
  localparam logic [5:0] OP_JAL          = 6'd16;
  localparam logic [5:0] OP_JALR         = 6'd17;
  localparam logic [5:0] OP_BEQ          = 6'd18;
  localparam logic [5:0] OP_BNE          = 6'd19;
  localparam logic [5:0] OP_BLT          = 6'd20;
  localparam logic [5:0] OP_BGE          = 6'd21;
  localparam logic [5:0] OP_BLTU         = 6'd22;
  localparam logic [5:0] OP_BGEU         = 6'd23;
  localparam logic [5:0] OP_OTHER_BRANCH = 6'd24;
  localparam logic [5:0] OP_LB           = 6'd25;
  localparam logic [5:0] OP_LH           = 6'd26;
  localparam logic [5:0] OP_LW           = 6'd27;
  localparam logic [5:0] OP_LD           = 6'd28;
  localparam logic [5:0] OP_LBU          = 6'd29;
  localparam logic [5:0] OP_LHU          = 6'd30;
  localparam logic [5:0] OP_LWU          = 6'd31;
  localparam logic [5:0] OP_SB           = 6'd32;
  localparam logic [5:0] OP_SH           = 6'd33;
  localparam logic [5:0] OP_SW           = 6'd34;
  localparam logic [5:0] OP_SD           = 6'd35;
  localparam logic [5:0] OP_ECALL        = 6'd36;
  localparam logic [5:0] OP_OTHER_SYS    = 6'd37;
  localparam logic [5:0] OP_UNKNOWN      = 6'd38;

  // Stage 1 -> stage 2: raw word, address, major class
  typedef struct packed {
    logic [31:0]           word;
    logic [ADDR_WIDTH-1:0] pc;
    cls_t                  cls;
  } s1_t;

  // Stage 2 -> stage 3: decoded fields, offset and address
  typedef struct packed {
    logic [5:0]            code;
    logic signed [31:0]    imm;
    logic [ADDR_WIDTH-1:0] pc;
    logic                  add_en;
    logic [4:0]            rd;
    logic [4:0]            rs1;
    logic [4:0]            rs2;
    logic [2:0]            f3;
    logic [6:0]            f7;
  } s2_t;

endpackage

// ----- design/rvd_if.sv -----
// Request channels of the instruction decoder: instruction in, decode out.
// No dependencies.
interface rvd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [63:0] pc;

  modport source (output valid, output instr_word, output pc, input ready);
  modport sink   (input valid, input instr_word, input pc, output ready);
endinterface

interface rvd_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         op_code;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [31:0] immediate;
  logic [63:0]        target_addr;
  logic [2:0]         funct3_field;
  logic [6:0]         funct7_field;

  modport source (output valid, output op_code, output dest_reg, output src1_reg,
                  output src2_reg, output immediate, output target_addr,
                  output funct3_field, output funct7_field, input ready);
  modport sink   (input valid, input op_code, input dest_reg, input src1_reg,
                  input src2_reg, input immediate, input target_addr,
                  input funct3_field, input funct7_field, output ready);
endinterface

// ----- design/rvd_classify.sv -----
// Stage 1: accept a request and register it with its major opcode class.
// Depends on rvd_pkg and rvd_in_if.
module rvd_classify (
  input  logic          clk,
  input  logic          rst_n,
  rvd_in_if.sink        in_chan,
  output logic          s1_valid,
  input  logic          s1_ready,
  output rvd_pkg::s1_t  s1
);
  import rvd_pkg::*;

  logic stage_ready;
  logic valid_r, valid_nxt;
  s1_t  data_r;
  cls_t cls;

  assign stage_ready   = !valid_r || s1_ready;
  assign in_chan.ready = stage_ready;

  always_comb begin
    case (in_chan.instr_word[6:0] & OPC_MASK)
      OPC_OP_IMM: cls = CLS_OP_IMM;
      OPC_OP:     cls = CLS_OP;
      OPC_AUIPC:  cls = CLS_AUIPC;
      OPC_LUI:    cls = CLS_LUI;
      OPC_JAL:    cls = CLS_JAL;
      OPC_JALR:   cls = CLS_JALR;
      OPC_BRANCH: cls = CLS_BRANCH;
      OPC_LOAD:   cls = CLS_LOAD;
      OPC_STORE:  cls = CLS_STORE;
      OPC_SYSTEM: cls = CLS_SYSTEM;
      default:    cls = CLS_NONE;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (stage_ready) begin
      valid_nxt = in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (stage_ready && in_chan.valid) begin
      data_r.word <= in_chan.instr_word;
      data_r.pc   <= in_chan.pc[ADDR_WIDTH-1:0];
      data_r.cls  <= cls;
    end
  end

  assign s1_valid = valid_r;
  assign s1       = data_r;

endmodule

// ----- design/rvd_decode.sv -----
// Stage 2: mnemonic code, immediate assembly and register fields.
// Depends on rvd_pkg and the assertion macro header.
module rvd_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  output logic          s1_ready,
  input  rvd_pkg::s1_t  s1,
  output logic          s2_valid,
  input  logic          s2_ready,
  output rvd_pkg::s2_t  s2
);
  import rvd_pkg::*;
  `include "rv64_instruction_decoder_core_assert.svh"

  logic        stage_ready;
  logic        valid_r, valid_nxt;
  s2_t         data_r, data_nxt;
  logic [31:0] w;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;

  assign w     = s1.word;
  assign f3    = w[14:12];
  assign f7    = w[31:25];
  assign imm_i = {{20{w[31]}}, w[31:20]};

  assign stage_ready = !valid_r || s2_ready;
  assign s1_ready    = stage_ready;

  always_comb begin
    data_nxt        = '0;
    data_nxt.code   = OP_UNKNOWN;
    data_nxt.pc     = s1.pc;
    data_nxt.rd     = w[11:7];
    data_nxt.rs1    = w[19:15];
    data_nxt.rs2    = w[24:20];
    data_nxt.f3     = f3;
    data_nxt.f7     = f7;
    case (s1.cls)
      CLS_OP_IMM: begin
        data_nxt.imm = imm_i;
        case (f3)
          3'd0: data_nxt.code = OP_ADDI;
          3'd6: data_nxt.code = OP_ORI;
          3'd7: data_nxt.code = OP_ANDI;
          3'd4: data_nxt.code = OP_XORI;
          3'd1: begin
            data_nxt.code = OP_SLLI;
            data_nxt.imm  = {26'd0, w[25:20]};
          end
          3'd5: begin
            data_nxt.code = f7[5] ? OP_SRAI : OP_SRLI;
            data_nxt.imm  = {26'd0, w[25:20]};
          end
          default: data_nxt.code = OP_OTHER_IMM;
        endcase
      end
      CLS_OP: begin
        if (f3 == 3'd0 && f7 == F7_BASE) begin
          data_nxt.code = OP_ADD;
        end else if (f3 == 3'd0 && f7 == F7_ALT) begin
          data_nxt.code = OP_SUB;
        end else begin
          case (f3)
            3'd7:    data_nxt.code = OP_AND;
            3'd6:    data_nxt.code = OP_OR;
            3'd4:    data_nxt.code = OP_XOR;
            default: data_nxt.code = OP_OTHER_OP;
          endcase
        end
      end
      CLS_AUIPC: begin
        data_nxt.code = OP_AUIPC;
        data_nxt.imm  = {{12{w[31]}}, w[31:12]};
      end
      CLS_LUI: begin
        data_nxt.code = OP_LUI;
        data_nxt.imm  = {{12{w[31]}}, w[31:12]};
      end
      CLS_JAL: begin
        data_nxt.code   = OP_JAL;
        data_nxt.imm    = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        data_nxt.add_en = 1'b1;
      end
      CLS_JALR: begin
        data_nxt.code = OP_JALR;
        data_nxt.imm  = imm_i;
      end
      CLS_BRANCH: begin
        data_nxt.imm    = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        data_nxt.add_en = 1'b1;
        case (f3)
          3'd0:    data_nxt.code = OP_BEQ;
          3'd1:    data_nxt.code = OP_BNE;
          3'd4:    data_nxt.code = OP_BLT;
          3'd5:    data_nxt.code = OP_BGE;
          3'd6:    data_nxt.code = OP_BLTU;
          3'd7:    data_nxt.code = OP_BGEU;
          default: data_nxt.code = OP_OTHER_BRANCH;
        endcase
      end
      CLS_LOAD: begin
        data_nxt.imm = imm_i;
        case (f3)
          3'd0:    data_nxt.code = OP_LB;
          3'd1:    data_nxt.code = OP_LH;
          3'd2:    data_nxt.code = OP_LW;
          3'd4:    data_nxt.code = OP_LBU;
          3'd5:    data_nxt.code = OP_LHU;
          3'd6:    data_nxt.code = OP_LWU;
          default: data_nxt.code = OP_LD;   // doubleword, and funct3 7
        endcase
      end
      CLS_STORE: begin
        data_nxt.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          3'd0:    data_nxt.code = OP_SB;
          3'd1:    data_nxt.code = OP_SH;
          3'd2:    data_nxt.code = OP_SW;
          default: data_nxt.code = OP_SD;   // funct3 3 and every wider code
        endcase
      end
      CLS_SYSTEM: begin
        data_nxt.code = (w == ECALL_WORD) ? OP_ECALL : OP_OTHER_SYS;
      end
      default: data_nxt.code = OP_UNKNOWN;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (stage_ready) begin
      valid_nxt = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && s1_valid) begin
      data_r <= data_nxt;
    end
  end

  assign s2_valid = valid_r;
  assign s2       = data_r;

  // A stalled decode entry must neither vanish nor change
  `RVD_ASSERT_NEXT(a_stall_hold, clk, rst_n, valid_r && !s2_ready, valid_r && $stable(data_r))

endmodule

// ----- design/rvd_target.sv -----
// Stage 3: branch and jump target adder, and the output register.
// Depends on rvd_pkg, rvd_out_if and the assertion macro header.
module rvd_target (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s2_valid,
  output logic          s2_ready,
  input  rvd_pkg::s2_t  s2,
  rvd_out_if.source     out_chan
);
  import rvd_pkg::*;
  `include "rv64_instruction_decoder_core_assert.svh"

  logic                         stage_ready;
  logic                         valid_r, valid_nxt;
  logic signed [ADDR_WIDTH-1:0] offset;
  logic [ADDR_WIDTH-1:0]        sum;
  logic [63:0]                  target_nxt;

  logic [5:0]         code_r;
  logic [4:0]         rd_r, rs1_r, rs2_r;
  logic signed [31:0] imm_r;
  logic [63:0]        target_r;
  logic [2:0]         f3_r;
  logic [6:0]         f7_r;

  logic               jump_code;
  logic               upper_code;

  assign stage_ready = !valid_r || out_chan.ready;
  assign s2_ready    = stage_ready;

  // Sign-extend the offset to the address width; the sum wraps there
  assign offset     = ADDR_WIDTH'(s2.imm);
  assign sum        = s2.pc + offset;
  assign target_nxt = s2.add_en ? 64'(sum) : 64'd0;

  always_comb begin
    valid_nxt = valid_r;
    if (stage_ready) begin
      valid_nxt = s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && s2_valid) begin
      code_r   <= s2.code;
      rd_r     <= s2.rd;
      rs1_r    <= s2.rs1;
      rs2_r    <= s2.rs2;
      imm_r    <= s2.imm;
      target_r <= target_nxt;
      f3_r     <= s2.f3;
      f7_r     <= s2.f7;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.op_code      = code_r;
  assign out_chan.dest_reg     = rd_r;
  assign out_chan.src1_reg     = rs1_r;
  assign out_chan.src2_reg     = rs2_r;
  assign out_chan.immediate    = imm_r;
  assign out_chan.target_addr  = target_r;
  assign out_chan.funct3_field = f3_r;
  assign out_chan.funct7_field = f7_r;

  assign jump_code  = code_r inside {OP_JAL, [OP_BEQ:OP_OTHER_BRANCH]};
  assign upper_code = code_r inside {OP_LUI, OP_AUIPC};

  // Only JAL and branches carry a target
  `RVD_ASSERT_NOW(a_target_zero, clk, rst_n, valid_r && !jump_code, target_r == 64'd0)
  // Jump and branch offsets are halfword aligned
  `RVD_ASSERT_NOW(a_offset_even, clk, rst_n, valid_r && jump_code, imm_r[0] == 1'b0)
  // Upper immediates carry the raw funct7 bits in place
  `RVD_ASSERT_NOW(a_upper_imm, clk, rst_n, valid_r && upper_code, imm_r[19:13] == f7_r)

endmodule

// ----- design/rv64_instruction_decoder_core.sv -----
// Top level of the RV64I instruction decoder: three-stage decode pipeline.
// Depends on rvd_pkg, rvd_if, rvd_classify, rvd_decode and rvd_target.
//
// Decodes one 32-bit RISC-V instruction word per cycle, with its address,
// while out_chan is not stalled. Each request on in_chan yields exactly one
// result on out_chan, in order; the classify, field decode and target add
// stages register it in turn, and the result is held until out_chan takes
// it. The sustained rate is one request per clock while out_chan is ready,
// each of the three register stages taking a new request whenever the
// stage ahead of it is empty or draining. The result carries
// a dense mnemonic code (38 for an unrecognized major opcode), the raw rd,
// rs1, rs2, funct3 and funct7 fields, the sign-extended immediate (shift
// amount for slli/srli/srai, upper 20 bits for lui/auipc), and for JAL and
// every branch the target pc + offset wrapped at ADDR_WIDTH bits; the target
// reads zero for all other instructions. The block holds no architectural
// state: reset only empties the pipeline.
module rv64_instruction_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  rvd_in_if.sink     in_chan,
  rvd_out_if.source  out_chan
);
  import rvd_pkg::*;

  // Stage 1 -> 2 link
  logic s1_valid;
  logic s1_ready;
  s1_t  s1;

  // Stage 2 -> 3 link
  logic s2_valid;
  logic s2_ready;
  s2_t  s2;

  // Register the request and sort it by major opcode
  rvd_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  // Pick the mnemonic, assemble the immediate, flag target-bearing codes
  rvd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  // Add the offset to the address and hold the result for the consumer
  rvd_target u_target (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2),
    .out_chan (out_chan)
  );

endmodule

// ----- tb/sv/rv64_instruction_decoder_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for rv64_instruction_decoder_core: directed and random decode requests.
// Depends on rvd_pkg, rvd_if and the decoder RTL; each result is checked against a local decode model.
module rv64_instruction_decoder_core_tb;
  import rvd_pkg::*;

  // Idle counts: a watchdog trips when no request moves for this many cycles.
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;

  // funct3 values used to build directed words
  localparam logic [2:0] F3_ADD      = 3'd0;
  localparam logic [2:0] F3_SLL      = 3'd1;
  localparam logic [2:0] F3_SLT      = 3'd2;
  localparam logic [2:0] F3_SR       = 3'd5;
  localparam logic [2:0] F3_AND      = 3'd7;
  localparam logic [2:0] F3_BEQ      = 3'd0;
  localparam logic [2:0] F3_BR_BAD   = 3'd2;
  localparam logic [2:0] F3_BGEU     = 3'd7;
  localparam logic [2:0] F3_LW       = 3'd2;
  localparam logic [2:0] F3_LD_ALIAS = 3'd7;
  localparam logic [2:0] F3_SD       = 3'd3;
  localparam logic [2:0] F3_SD_ALIAS = 3'd5;

  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

  // Mnemonic per funct3 for the classes that decode by table; index is funct3.
  localparam logic [7:0][5:0] IMM_OPS = {OP_ANDI, OP_ORI, OP_SRLI, OP_XORI,
                                         OP_OTHER_IMM, OP_OTHER_IMM, OP_SLLI, OP_ADDI};
  localparam logic [7:0][5:0] ALU_OPS = {OP_AND, OP_OR, OP_OTHER_OP, OP_XOR,
                                         OP_OTHER_OP, OP_OTHER_OP, OP_OTHER_OP, OP_ADD};
  localparam logic [7:0][5:0] BRANCH_OPS = {OP_BGEU, OP_BLTU, OP_BGE, OP_BLT,
                                            OP_OTHER_BRANCH, OP_OTHER_BRANCH, OP_BNE, OP_BEQ};
  localparam logic [7:0][5:0] LOAD_OPS = {OP_LD, OP_LWU, OP_LHU, OP_LBU,
                                          OP_LD, OP_LW, OP_LH, OP_LB};
  localparam logic [7:0][5:0] STORE_OPS = {OP_SD, OP_SD, OP_SD, OP_SD,
                                           OP_SD, OP_SW, OP_SH, OP_SB};

  localparam logic [9:0][6:0] MAJOR_OPS = {OPC_OP_IMM, OPC_OP, OPC_AUIPC, OPC_LUI, OPC_JAL,
                                           OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
                                           OPC_SYSTEM};

  typedef struct packed {
    logic [5:0]         code;
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic signed [31:0] imm;
    logic [63:0]        target;
    logic [2:0]         f3;
    logic [6:0]         f7;
  } decoded_t;

  logic clk = 1'b0;
  logic rst_n;

  rvd_in_if  in_chan ();
  rvd_out_if out_chan ();

  rv64_instruction_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #4 clk = ~clk;

  decoded_t pending_decodes[$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  int       results_seen   = 0;
  // Set to run both sides at full rate with no gaps or stalls.
  bit       steady_flow    = 1'b0;

  // ---------------------------------------------------------------------------
  // Decode model: mnemonic, raw fields, immediate and wrapped target.
  // ---------------------------------------------------------------------------
  function automatic decoded_t predict_decode(logic [31:0] w, logic [63:0] addr);
    decoded_t    d;
    logic [31:0] i_imm;
    logic [63:0] addr_mask;
    logic        has_target;
    addr_mask    = {64{1'b1}} >> (64 - ADDR_WIDTH);
    i_imm        = {{20{w[31]}}, w[31:20]};
    has_target   = 1'b0;
    d.code       = OP_UNKNOWN;
    d.rd         = w[11:7];
    d.rs1        = w[19:15];
    d.rs2        = w[24:20];
    d.f3         = w[14:12];
    d.f7         = w[31:25];
    d.imm        = '0;
    d.target     = '0;
    case (w[6:0])
      OPC_OP_IMM: begin
        d.code = IMM_OPS[w[14:12]];
        d.imm  = i_imm;
        // Shifts carry a 6-bit zero-extended shift amount; bit 30 picks arithmetic.
        if (d.code == OP_SLLI || d.code == OP_SRLI) begin
          d.imm = {26'd0, w[25:20]};
          if (d.code == OP_SRLI && w[30]) d.code = OP_SRAI;
        end
      end
      OPC_OP: begin
        d.code = ALU_OPS[w[14:12]];
        if (d.code == OP_ADD) begin
          if (w[31:25] == F7_ALT) d.code = OP_SUB;
          else if (w[31:25] != F7_BASE) d.code = OP_OTHER_OP;
        end
      end
      OPC_AUIPC: begin
        d.code = OP_AUIPC;
        d.imm  = {{12{w[31]}}, w[31:12]};
      end
      OPC_LUI: begin
        d.code = OP_LUI;
        d.imm  = {{12{w[31]}}, w[31:12]};
      end
      OPC_JAL: begin
        d.code     = OP_JAL;
        d.imm      = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        has_target = 1'b1;
      end
      OPC_JALR: begin
        d.code = OP_JALR;
        d.imm  = i_imm;
      end
      OPC_BRANCH: begin
        // Reserved funct3 still gets a target.
        d.code     = BRANCH_OPS[w[14:12]];
        d.imm      = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        has_target = 1'b1;
      end
      OPC_LOAD: begin
        d.code = LOAD_OPS[w[14:12]];
        d.imm  = i_imm;
      end
      OPC_STORE: begin
        d.code = STORE_OPS[w[14:12]];
        d.imm  = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OPC_SYSTEM: d.code = (w == ECALL_WORD) ? OP_ECALL : OP_OTHER_SYS;
      default: ;
    endcase
    if (has_target)
      d.target = ((addr & addr_mask) + {{32{d.imm[31]}}, d.imm}) & addr_mask;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Instruction builders for directed words.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] mk_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                       logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] mk_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                       logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] mk_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                       logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] mk_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                       logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] mk_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Addresses cluster near zero and near the top so targets wrap both ways.
  function automatic logic [63:0] pick_pc();
    case ($urandom_range(0, 3))
      0: return {32'd0, 32'($urandom_range(0, 4095))};
      1: return {64{1'b1}} - 64'($urandom_range(0, 4095));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Known major opcode with random fields; bias OP toward add/sub and SYSTEM toward ecall.
  function automatic logic [31:0] pick_well_formed();
    logic [31:0] w;
    w      = $urandom;
    w[6:0] = MAJOR_OPS[$urandom_range(0, 9)];
    if (w[6:0] == OPC_OP && $urandom_range(0, 1) == 1)
      w[31:25] = ($urandom_range(0, 1) == 1) ? F7_ALT : F7_BASE;
    if (w[6:0] == OPC_SYSTEM && $urandom_range(0, 3) == 0)
      w = ECALL_WORD;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: optional gap, then hold the request until accepted.
  // Entered and left at a rising edge; valid gets one assignment per step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [31:0] w, input logic [63:0] addr);
    int gap;
    gap = pick_idle_len();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.instr_word <= w;
    in_chan.pc         <= addr;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("[%0t] result %0d: %s got %h expected %h", $time, results_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes, each instruction class and every documented corner.
  task automatic test_directed_cases();
    send_request(mk_i(12'h800, 5'd31, F3_ADD, 5'd31, OPC_OP_IMM), 64'd0);
    send_request(mk_i(12'h7ff, 5'd0, F3_AND, 5'd0, OPC_OP_IMM), {64{1'b1}});
    send_request(mk_r(7'h01, 5'd31, 5'd3, F3_SLL, 5'd4, OPC_OP_IMM), 64'h10);
    send_request(mk_r(F7_ALT, 5'd31, 5'd9, F3_SR, 5'd10, OPC_OP_IMM), 64'h20);
    send_request(mk_r(F7_BASE, 5'd7, 5'd1, F3_SR, 5'd2, OPC_OP_IMM), 64'h24);
    // Unmatched OP-IMM still reports the I-type immediate.
    send_request(mk_i(12'hfff, 5'd5, F3_SLT, 5'd6, OPC_OP_IMM), 64'h28);
    send_request(mk_r(F7_BASE, 5'd3, 5'd2, F3_ADD, 5'd1, OPC_OP), 64'h2c);
    send_request(mk_r(F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP), 64'h30);
    // Unmatched OP: an add with a foreign funct7.
    send_request(mk_r(7'h01, 5'd8, 5'd7, F3_ADD, 5'd6, OPC_OP), 64'h34);
    send_request({20'hfffff, 5'd5, OPC_LUI}, 64'h38);
    send_request({20'h80000, 5'd0, OPC_AUIPC}, {$urandom, $urandom});
    // Jumps and branches wrapping below zero and past the top.
    send_request(mk_j(21'h100000, 5'd1), 64'd0);
    send_request(mk_j(21'h0ffffe, 5'd0), {64{1'b1}});
    send_request(mk_i(12'hfff, 5'd1, F3_ADD, 5'd0, OPC_JALR), 64'h40);
    send_request(mk_b(13'h1000, 5'd31, 5'd0, F3_BEQ), 64'd4);
    send_request(mk_b(13'h0ffe, 5'd1, 5'd2, F3_BGEU), 64'hffff_ffff_ffff_fff0);
    // Reserved branch funct3 keeps its target.
    send_request(mk_b(13'h0ffe, 5'd3, 5'd4, F3_BR_BAD), 64'hffff_ffff_ffff_f800);
    send_request(mk_i(12'h123, 5'd31, F3_LW, 5'd31, OPC_LOAD), 64'h50);
    send_request(mk_i(12'h800, 5'd2, F3_LD_ALIAS, 5'd3, OPC_LOAD), 64'h54);
    send_request(mk_s(12'h800, 5'd31, 5'd31, F3_SD), 64'h58);
    send_request(mk_s(12'h7ff, 5'd1, 5'd2, F3_SD_ALIAS), 64'h5c);
    send_request(ECALL_WORD, 64'h60);
    send_request(EBREAK_WORD, 64'h64);
    send_request(32'h0000_0000, 64'h68);
    send_request(32'hffff_ffff, {64{1'b1}});
  endtask

  // Back-to-back requests with the sink always ready.
  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    repeat (count) send_request(pick_well_formed(), pick_pc());
    steady_flow = 1'b0;
  endtask

  // Known opcodes with random content under random gaps and stalls.
  task automatic test_well_formed_stream(input int count);
    repeat (count) send_request(pick_well_formed(), pick_pc());
  endtask

  // Fully random words: mostly unrecognized opcodes.
  task automatic test_raw_words(input int count);
    repeat (count) send_request($urandom, {$urandom, $urandom});
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on each accepted request, check each accepted result.
  // Both in one block so a request and result in the same edge stay ordered.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    decoded_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        pending_decodes.push_back(predict_decode(in_chan.instr_word, in_chan.pc));
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (pending_decodes.size() == 0) begin
          report_mismatch("result with no pending request, op_code", 64'(out_chan.op_code),
                          64'd0);
        end else begin
          want = pending_decodes.pop_front();
          if (out_chan.op_code !== want.code)
            report_mismatch("op_code", 64'(out_chan.op_code), 64'(want.code));
          if (out_chan.dest_reg !== want.rd)
            report_mismatch("dest_reg", 64'(out_chan.dest_reg), 64'(want.rd));
          if (out_chan.src1_reg !== want.rs1)
            report_mismatch("src1_reg", 64'(out_chan.src1_reg), 64'(want.rs1));
          if (out_chan.src2_reg !== want.rs2)
            report_mismatch("src2_reg", 64'(out_chan.src2_reg), 64'(want.rs2));
          if (out_chan.immediate !== want.imm)
            report_mismatch("immediate", 64'(out_chan.immediate), 64'(want.imm));
          if (out_chan.target_addr !== want.target)
            report_mismatch("target_addr", out_chan.target_addr, want.target);
          if (out_chan.funct3_field !== want.f3)
            report_mismatch("funct3_field", 64'(out_chan.funct3_field), 64'(want.f3));
          if (out_chan.funct7_field !== want.f7)
            report_mismatch("funct7_field", 64'(out_chan.funct7_field), 64'(want.f7));
        end
      end
    end
  end

  // Watchdog: count edges at which neither side moves a request.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result sink: ready bursts broken by stalls; no stalls in steady-flow phases.
  initial begin : drive_sink
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      stall = pick_idle_len();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.instr_word <= '0;
    in_chan.pc         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_back_to_back(150);
    test_well_formed_stream(925);
    test_raw_words(250);

    // Drop valid, let the pipeline drain, then keep clocking
    // to catch any stray result.
    in_chan.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- rv64_instruction_decoder_core.f -----
+incdir+design
design/rvd_pkg.sv
design/rvd_if.sv
design/rvd_classify.sv
design/rvd_decode.sv
design/rvd_target.sv
design/rv64_instruction_decoder_core.sv
tb/sv/rv64_instruction_decoder_core_tb.sv
